// ----- design/iir_q16_pkg.sv -----
package iir_q16_pkg;

    localparam int MAX_ORDER = 3;
    localparam int DATA_W    = 32;
    localparam int ORDER_W   = 2;
    localparam int INDEX_W   = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ORDER_W-1:0]       order_t;

    // configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_ORDER = 3'd0,
        REG_B0    = 3'd1,
        REG_B1    = 3'd2,
        REG_B2    = 3'd3,
        REG_B3    = 3'd4,
        REG_A1    = 3'd5,
        REG_A2    = 3'd6,
        REG_A3    = 3'd7
    } cfg_reg_t;

    localparam order_t RESET_ORDER = order_t'(MAX_ORDER);
    localparam data_t  RESET_B0    = 32'sd65536;

    // bp[k] weighs the input k+1 samples back, ap[k] the output k+1 samples back
    typedef struct packed {
        order_t                    order;
        data_t                     b0;
        data_t [MAX_ORDER-1:0]     bp;
        data_t [MAX_ORDER-1:0]     ap;
    } coeff_t;

    // pass-through setting after reset
    localparam coeff_t RESET_COEFF = '{order: RESET_ORDER, b0: RESET_B0, bp: '0, ap: '0};

    localparam logic signed [DATA_W:0] SAT_MAX33 = 33'sh0_7FFF_FFFF;
    localparam logic signed [DATA_W:0] SAT_MIN33 = -33'sh0_8000_0000;

    function automatic data_t sat33(input logic signed [DATA_W:0] v);
        data_t r;
        if (v > SAT_MAX33)
            r = data_t'(SAT_MAX33[DATA_W-1:0]);
        else if (v < SAT_MIN33)
            r = data_t'(SAT_MIN33[DATA_W-1:0]);
        else
            r = data_t'(v[DATA_W-1:0]);
        return r;
    endfunction

    function automatic data_t q_add(input data_t a, input data_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    function automatic data_t q_sub(input data_t a, input data_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    // q16.16 multiply, round half away from zero, saturate
    function automatic data_t q_mul(input data_t a, input data_t b);
        logic signed [2*DATA_W-1:0] p;
        logic        [2*DATA_W-1:0] mag;
        logic        [2*DATA_W-1:0] rnd;
        logic signed [2*DATA_W-1:0] q;
        data_t                      r;
        p   = (2*DATA_W)'(a) * (2*DATA_W)'(b);
        mag = p[2*DATA_W-1] ? (2*DATA_W)'(-p) : p;
        rnd = (mag + (2*DATA_W)'(32'h8000)) >> 16;
        q   = p[2*DATA_W-1] ? -$signed(rnd) : $signed(rnd);
        if (q > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (q < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = data_t'(q[DATA_W-1:0]);
        return r;
    endfunction

endpackage

// ----- design/iir_q16_cfg.sv -----
module iir_q16_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [iir_q16_pkg::INDEX_W-1:0]      cfg_index,
    input  logic [iir_q16_pkg::DATA_W-1:0]       cfg_data,
    output iir_q16_pkg::coeff_t                  coeff
);
    import iir_q16_pkg::*;

    coeff_t coeff_reg;
    coeff_t coeff_next;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORDER: coeff_next.order = cfg_data[ORDER_W-1:0];
                REG_B0:    coeff_next.b0    = data_t'(cfg_data);
                REG_B1:    coeff_next.bp[0] = data_t'(cfg_data);
                REG_B2:    coeff_next.bp[1] = data_t'(cfg_data);
                REG_B3:    coeff_next.bp[2] = data_t'(cfg_data);
                REG_A1:    coeff_next.ap[0] = data_t'(cfg_data);
                REG_A2:    coeff_next.ap[1] = data_t'(cfg_data);
                REG_A3:    coeff_next.ap[2] = data_t'(cfg_data);
                default:   coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= RESET_COEFF;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

endmodule

// ----- design/iir_q16_mac.sv -----
module iir_q16_mac (
    input  iir_q16_pkg::data_t                              x0,
    input  iir_q16_pkg::data_t [iir_q16_pkg::MAX_ORDER-1:0] x_hist,
    input  iir_q16_pkg::data_t [iir_q16_pkg::MAX_ORDER-1:0] y_hist,
    input  iir_q16_pkg::coeff_t                             coeff,
    output iir_q16_pkg::data_t                              y0
);
    import iir_q16_pkg::*;

    data_t                 head;
    data_t [MAX_ORDER-1:0] term;

    // all products side by side: b0*x0, then a forward and a feedback product per tap
    assign head = q_mul(coeff.b0, x0);

    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_tap
        assign term[k] = q_sub(q_mul(coeff.bp[k], x_hist[k]),
                               q_mul(coeff.ap[k], y_hist[k]));
    end

    // saturating accumulate over the taps in use, in tap order
    always_comb
    begin
        data_t acc;
        acc = head;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (k < int'(coeff.order))
                acc = q_add(acc, term[k]);
        end
        y0 = acc;
    end

endmodule

// ----- design/iir_q16_filter.sv -----
// iir_filter_q16: direct-form-I IIR filter on signed Q16.16 samples, up to three past
// taps. Each input beat on s_axis gives exactly one output beat on m_axis:
// y0 = b0*x0 + sum over k=1..order of (bk*xk - ak*yk), every product rounded to nearest
// (ties away from zero) and saturated, every add and subtract saturated to 32 bits.
// Throughput is one sample per clock while m_axis is ready; each accepted input beat goes
// through the input register, then the result register. The output of each
// sample feeds the next one, so the whole multiply-accumulate, seven 32x32 products and
// a three-step saturating sum, sits in the single path from the input register to the
// result register and the history registers. Coefficients and the order are written on
// the cfg channel (index 0 order, 1..4 b0..b3, 5..7 a1..a3), which is always ready; write
// them only while no sample is in flight. After reset the filter passes samples through
// (b0 = 1.0, others zero, order 3) and both histories are zero.
module iir_filter_q16 (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [iir_q16_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] sample_in
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [iir_q16_pkg::DATA_W-1:0]     m_axis_tdata,   // [31:0] sample_out
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [iir_q16_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [iir_q16_pkg::DATA_W-1:0]     cfg_data
);
    import iir_q16_pkg::*;

    coeff_t coeff;

    // input register
    logic  in_valid_reg;
    logic  in_valid_next;
    data_t x_reg;

    // result register
    logic  out_valid_reg;
    logic  out_valid_next;
    data_t y_reg;

    // sample histories, entry 0 is one sample back
    data_t [MAX_ORDER-1:0] x_hist_reg;
    data_t [MAX_ORDER-1:0] x_hist_next;
    data_t [MAX_ORDER-1:0] y_hist_reg;
    data_t [MAX_ORDER-1:0] y_hist_next;

    data_t y0;
    logic  advance;     // result register free to take the next result
    logic  load;        // a sample moves from the input register into the result
    logic  s_beat;

    assign cfg_ready = 1'b1;

    iir_q16_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeff     (coeff)
    );

    iir_q16_mac u_mac (
        .x0     (x_reg),
        .x_hist (x_hist_reg),
        .y_hist (y_hist_reg),
        .coeff  (coeff),
        .y0     (y0)
    );

    // handshake: result register parts the two sides
    assign advance       = !out_valid_reg || m_axis_tready;
    assign load          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        x_hist_next    = x_hist_reg;
        y_hist_next    = y_hist_reg;
        if (advance)
            out_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        if (load)
        begin
            // histories always shift over full depth, whatever the order
            for (int k = MAX_ORDER - 1; k > 0; k--)
            begin
                x_hist_next[k] = x_hist_reg[k-1];
                y_hist_next[k] = y_hist_reg[k-1];
            end
            x_hist_next[0] = x_reg;
            y_hist_next[0] = y0;
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x_hist_reg    <= '0;
            y_hist_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            x_hist_reg    <= x_hist_next;
            y_hist_reg    <= y_hist_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_beat)
            x_reg <= data_t'(s_axis_tdata);
        if (load)
            y_reg <= y0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = y_reg;

`ifndef SYNTHESIS
    // the beat on offer is always the newest output history entry
    a_out_is_newest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (y_reg == y_hist_reg[0]))
        else $error("output beat differs from newest output history");

    // input side stalls only when both registers are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // a sample moving on takes its place in the input history
    a_x_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (x_hist_reg[0] == $past(x_reg)))
        else $error("input history not updated on load");

    // a held sample reaches a free result register on the next edge
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("sample did not move into a free result register");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import iir_q16_pkg::*;

    // handy q16.16 values
    localparam data_t Q_POS_MAX = 32'sh7FFF_FFFF;
    localparam data_t Q_NEG_MAX = 32'sh8000_0000;
    localparam data_t Q_ONE     = 32'sh0001_0000;
    localparam data_t Q_HALF    = 32'sh0000_8000;
    localparam data_t Q_QUARTER = 32'sh0000_4000;

    // settle time for the pipeline to empty before touching registers
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_SAMPLES = 108;

    // dut ports, the inputs driven from here all known from time zero
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index     = '0;
    logic [DATA_W-1:0]   cfg_data      = '0;

    // filter shadow: configuration and both histories, reset values as after rst_n
    order_t cur_order                = RESET_ORDER;
    data_t  coef_b [0:MAX_ORDER]     = '{RESET_B0, '0, '0, '0};
    data_t  coef_a [1:MAX_ORDER]     = '{'0, '0, '0};
    data_t  x_hist [0:MAX_ORDER-1]   = '{'0, '0, '0};
    data_t  y_hist [0:MAX_ORDER-1]   = '{'0, '0, '0};

    // samples waiting to go out, filter outputs waiting to come back
    data_t  samples_q [$];
    data_t  expected_out_q [$];

    int     fail_count = 0;
    bit     idle_on    = 1'b1;
    int     gap_left   = 0;
    int     stall_left = 0;
    logic   drv_valid;
    data_t  drv_data;
    data_t  want_out;

    iir_filter_q16 DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // fixed-point helpers for the shadow filter
    // ---------------------------------------------------------------

    // clamp a wide value into the signed 32-bit range
    function automatic data_t clip32(input longint v);
        if (v > 64'sd2147483647)
            return Q_POS_MAX;
        if (v < -64'sd2147483648)
            return Q_NEG_MAX;
        return data_t'(v);
    endfunction

    // q16.16 product, magnitude rounded half up so ties go away from zero
    function automatic data_t fx_mul(input data_t a, input data_t b);
        longint prod;
        longint mag;
        prod = longint'(a) * longint'(b);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 64'sd32768) >>> 16;
        return clip32((prod < 0) ? -mag : mag);
    endfunction

    function automatic data_t fx_add(input data_t a, input data_t b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    function automatic data_t fx_sub(input data_t a, input data_t b);
        return clip32(longint'(a) - longint'(b));
    endfunction

    // one filter step: output for x, then both histories shift by one over full depth
    function automatic data_t filter_step(input data_t x);
        data_t acc;
        data_t fwd;
        data_t back;
        acc = fx_mul(coef_b[0], x);
        // taps past the current order are skipped, order zero gives b0*x alone
        for (int k = 1; k <= int'(cur_order); k++)
        begin
            fwd  = fx_mul(coef_b[k], x_hist[k-1]);
            back = fx_mul(coef_a[k], y_hist[k-1]);
            acc  = fx_add(acc, fx_sub(fwd, back));
        end
        for (int k = MAX_ORDER - 1; k > 0; k--)
        begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = acc;
        return acc;
    endfunction

    // mirror a register write into the shadow
    function automatic void apply_reg(input cfg_reg_t idx, input data_t val);
        case (idx)
            REG_ORDER: cur_order = val[ORDER_W-1:0];
            REG_B0:    coef_b[0] = val;
            REG_B1:    coef_b[1] = val;
            REG_B2:    coef_b[2] = val;
            REG_B3:    coef_b[3] = val;
            REG_A1:    coef_a[1] = val;
            REG_A2:    coef_a[2] = val;
            REG_A3:    coef_a[3] = val;
            default:   ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // random values
    // ---------------------------------------------------------------

    function automatic data_t pick_extreme();
        case ($urandom_range(0, 5))
            0:       return Q_POS_MAX;
            1:       return Q_NEG_MAX;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            default: return data_t'(32'sh0000_0001);
        endcase
    endfunction

    // half the samples moderate (within +-4.0) so the feedback path stays out of saturation now and then
    function automatic data_t rand_sample();
        case ($urandom_range(0, 7))
            0:          return pick_extreme();
            1, 2, 3:    return data_t'($urandom);
            default:    return data_t'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    // coefficients: mostly within +-1.0, some full range, some corner values
    function automatic data_t rand_coeff();
        case ($urandom_range(0, 5))
            0:          return data_t'($urandom);
            1:          return pick_extreme();
            default:    return data_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // config channel, only used while nothing is in flight
    // ---------------------------------------------------------------

    // called at a rising edge, returns at the edge where the beat went through
    task automatic write_reg(input cfg_reg_t idx, input data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic set_coeffs(input order_t ord, input data_t b0, input data_t b1,
                              input data_t b2, input data_t b3, input data_t a1,
                              input data_t a2, input data_t a3);
        write_reg(REG_ORDER, data_t'(ord));
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_B3, b3);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_A3, a3);
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every output is back, then the pipe gets time to empty;
    // checked on the falling edge so the driver's and monitor's updates have settled
    task automatic wait_idle();
        while (samples_q.size() != 0 || s_axis_tvalid || expected_out_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // input driver: pops pending samples, predicts each accepted beat
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            // beat accepted at this edge, its output is now owed
            if (s_axis_tvalid)
                expected_out_q.push_back(filter_step(data_t'(s_axis_tdata)));
            drv_valid = 1'b0;
            drv_data  = data_t'(s_axis_tdata);
            if (gap_left > 0)
                gap_left--;
            else if (samples_q.size() > 0)
            begin
                drv_valid = 1'b1;
                drv_data  = samples_q.pop_front();
                // occasional burst of idle cycles after this beat
                if (idle_on && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 19);
            end
            // exactly one assignment per edge, valid stays high between back-to-back beats
            s_axis_tvalid <= drv_valid;
            s_axis_tdata  <= drv_data;
        end
    end

    // ---------------------------------------------------------------
    // output side: random back-pressure bursts
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 19);
        end
    end

    // ---------------------------------------------------------------
    // output monitor: each beat against the oldest owed output
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_out_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected output beat: sample_out %h", m_axis_tdata);
            end
            else
            begin
                want_out = expected_out_q.pop_front();
                if (m_axis_tdata !== want_out)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: sample_out expected %h got %h",
                                 want_out, m_axis_tdata);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset: pass-through, zero histories, field extremes
        samples_q.push_back('0);
        samples_q.push_back(data_t'(32'sh0000_0001));
        samples_q.push_back(-data_t'(32'sh0000_0001));
        samples_q.push_back(Q_POS_MAX);
        samples_q.push_back(Q_NEG_MAX);
        samples_q.push_back(Q_ONE);
        wait_idle();

        // order zero with tiny b0: rounding ties go away from zero, big unused taps
        set_coeffs(order_t'(0), data_t'(32'sh0000_0001), Q_POS_MAX, Q_NEG_MAX,
                   Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX);
        samples_q.push_back(Q_HALF);
        samples_q.push_back(-Q_HALF);
        samples_q.push_back(data_t'(32'sh0000_7FFF));
        samples_q.push_back(-data_t'(32'sh0000_7FFF));
        samples_q.push_back(data_t'(32'sh0001_8000));
        samples_q.push_back(-data_t'(32'sh0001_8000));
        wait_idle();

        // full order, every coefficient at the positive bound: products and sums saturate
        set_coeffs(order_t'(MAX_ORDER), Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX,
                   Q_POS_MAX, Q_POS_MAX, Q_POS_MAX);
        samples_q.push_back(Q_POS_MAX);
        samples_q.push_back(Q_NEG_MAX);
        samples_q.push_back(Q_POS_MAX);
        samples_q.push_back('0);
        samples_q.push_back(Q_NEG_MAX);
        wait_idle();

        // and at the negative bound
        set_coeffs(order_t'(MAX_ORDER), Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX,
                   Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX);
        samples_q.push_back(Q_NEG_MAX);
        samples_q.push_back(Q_POS_MAX);
        samples_q.push_back(Q_NEG_MAX);
        samples_q.push_back(data_t'(32'sh0000_0001));
        samples_q.push_back(-data_t'(32'sh0000_0001));
        wait_idle();

        // first-order low-pass, higher taps loaded but out of use
        set_coeffs(order_t'(1), Q_HALF, Q_QUARTER, Q_ONE, -Q_ONE, -Q_HALF,
                   Q_ONE, Q_ONE);
        samples_q.push_back(Q_ONE);
        samples_q.push_back(Q_ONE);
        samples_q.push_back(-Q_ONE);
        wait_idle();

        // random phases, each with a fresh setting; the last one runs without idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = (ph < RAND_PHASES - 1);
            set_coeffs(order_t'($urandom_range(0, MAX_ORDER)), rand_coeff(), rand_coeff(),
                       rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
            repeat (PHASE_SAMPLES) samples_q.push_back(rand_sample());
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_out_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
